/* src/fjkv_pkg.sv */
// Shared types and constants for the flat JSON key/value parser.
package fjkv_pkg;

    localparam int WINDOW_LEN = 4;
    localparam int FIELD_LEN  = 32;

    localparam int FILL_W  = $clog2(WINDOW_LEN);
    localparam int LEN_W   = $clog2(FIELD_LEN + 1);
    localparam int COUNT_W = 6;
    localparam int ACC_W   = 31;
    localparam int TDATA_W = 56;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam logic [7:0] CH_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CH_CLOSE  = 8'h7D;  // }
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;

    typedef enum logic [8:0] {
        PH_WAIT_CRLF = 9'b000000001,
        PH_WAIT_OPEN = 9'b000000010,
        PH_KEY_START = 9'b000000100,
        PH_KEY       = 9'b000001000,
        PH_COLON     = 9'b000010000,
        PH_VAL_START = 9'b000100000,
        PH_VAL       = 9'b001000000,
        PH_COMMA_END = 9'b010000000,
        PH_DONE      = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic               finished;
        logic               truncated;
        logic [COUNT_W-1:0] value_count;
        logic [COUNT_W-1:0] key_count;
        logic [7:0]         char_out;
        logic               value_char_valid;
        logic               key_char_valid;
        logic [ACC_W-1:0]   int_result;
        logic               pair_is_integer;
        logic               pair_done;
    } result_t;

endpackage

/* src/flat_json_key_value_parser_top.sv */
// Flat JSON key/value parser: byte-stream state machine with registered result.
//
// Usage:
//   Slave side carries one request per byte: s_tdata is the byte, s_tuser set
//   means restart (back to waiting for CR LF, lengths and integer cleared; the
//   window fill count is kept). Each accepted request yields exactly one result
//   on the master side: tuser flags say whether the byte was stored as a key
//   or string-value character, tdata carries the pair pulse, integer value,
//   byte, running lengths, truncation and finished flags.
//   m_tvalid rises in the cycle after acceptance; throughput, unless stalled, is
//   one byte per cycle, set by the single parse step between the state registers
//   and the result register (the times-ten add with saturation is the deepest path).
//   s_tready stays high while the result register is empty or being drained,
//   so a result can be taken and a new request accepted in the same cycle.
//   When the receiver stalls, the result holds and s_tready drops until it is
//   taken; parse state only moves on accepted requests.
//   Reset (rst_n low, asynchronous) returns to waiting for CR LF with an empty
//   window, zero lengths, zero integer and no pending result.
module flat_json_key_value_parser_top
    import fjkv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_in
    input  logic         s_tuser,   // [0] operation (restart)
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] pair_done, [1] pair_is_integer, [32:2] int_result, [40:33] char_out,
    // [46:41] key_count, [52:47] value_count, [53] truncated, [54] finished, [55] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser    // [0] key_char_valid, [1] value_char_valid
);

    phase_t             phase_reg, phase_next;
    logic [7:0]         win_reg  [WINDOW_LEN];
    logic [7:0]         win_next [WINDOW_LEN];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               int_mode_reg, int_mode_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [LEN_W-1:0]   key_len_reg, key_len_next;
    logic [LEN_W-1:0]   val_len_reg, val_len_next;
    logic               out_valid_reg;
    result_t            res_reg, res_next;

    logic               accept;
    logic [7:0]         c;
    logic               c_digit;
    logic               win_full;
    logic [ACC_W+3:0]   acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic               pair;
    logic               kv;
    logic               vv;
    logic               trunc;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign win_full = fill_reg >= FILL_W'(WINDOW_LEN - 1);

    // acc*10 + digit; the low nibble of an ASCII digit is its value
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {{(ACC_W){1'b0}}, c[3:0]};
    assign acc_sat = (acc_sum > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_sum[ACC_W-1:0];

    always_comb
    begin
        phase_next    = phase_reg;
        win_next      = win_reg;
        fill_next     = fill_reg;
        int_mode_next = int_mode_reg;
        acc_next      = acc_reg;
        key_len_next  = key_len_reg;
        val_len_next  = val_len_reg;
        pair          = 1'b0;
        kv            = 1'b0;
        vv            = 1'b0;
        trunc         = 1'b0;

        if (s_tuser)
        begin
            phase_next    = PH_WAIT_CRLF;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_next[i] = 8'h00;
            end
            int_mode_next = 1'b0;
            acc_next      = '0;
            key_len_next  = '0;
            val_len_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT_CRLF:
                begin
                    // slide once full, otherwise fill in place
                    for (int i = 0; i < WINDOW_LEN; i++)
                    begin
                        if (win_full)
                        begin
                            if (i == WINDOW_LEN - 1)
                                win_next[i] = c;
                            else
                                win_next[i] = win_reg[(i + 1) % WINDOW_LEN];
                        end
                        else if (fill_reg == FILL_W'(i))
                        begin
                            win_next[i] = c;
                        end
                    end
                    if (!win_full)
                        fill_next = fill_reg + FILL_W'(1);
                    if (win_next[0] == CH_CR && win_next[1] == CH_LF)
                        phase_next = PH_WAIT_OPEN;
                end
                PH_WAIT_OPEN:
                begin
                    if (c == CH_OPEN)
                        phase_next = PH_KEY_START;
                end
                PH_KEY_START:
                begin
                    if (c == CH_QUOTE)
                    begin
                        phase_next   = PH_KEY;
                        key_len_next = '0;
                    end
                end
                PH_KEY:
                begin
                    if (c == CH_QUOTE)
                        phase_next = PH_COLON;
                    else if (key_len_reg < LEN_W'(FIELD_LEN))
                    begin
                        key_len_next = key_len_reg + LEN_W'(1);
                        kv           = 1'b1;
                    end
                    else
                        trunc = 1'b1;
                end
                PH_COLON:
                begin
                    if (c == CH_COLON)
                        phase_next = PH_VAL_START;
                end
                PH_VAL_START:
                begin
                    if (c == CH_QUOTE)
                    begin
                        phase_next    = PH_VAL;
                        val_len_next  = '0;
                        int_mode_next = 1'b0;
                    end
                    else if (c_digit)
                    begin
                        phase_next    = PH_VAL;
                        val_len_next  = '0;
                        int_mode_next = 1'b1;
                        acc_next      = {{(ACC_W-4){1'b0}}, c[3:0]};
                    end
                end
                PH_VAL:
                begin
                    if (c == CH_QUOTE)
                    begin
                        phase_next = PH_COMMA_END;
                        pair       = 1'b1;
                    end
                    else if (int_mode_reg)
                    begin
                        if (c == CH_SPACE)
                        begin
                            phase_next = PH_COMMA_END;
                            pair       = 1'b1;
                        end
                        else if (c == CH_CLOSE)
                        begin
                            phase_next = PH_DONE;
                            pair       = 1'b1;
                        end
                        else if (c == CH_COMMA)
                        begin
                            phase_next = PH_KEY_START;
                            pair       = 1'b1;
                        end
                        else if (c_digit)
                            acc_next = acc_sat;
                    end
                    else if (val_len_reg < LEN_W'(FIELD_LEN))
                    begin
                        val_len_next = val_len_reg + LEN_W'(1);
                        vv           = 1'b1;
                    end
                    else
                        trunc = 1'b1;
                end
                PH_COMMA_END:
                begin
                    if (c == CH_COMMA)
                        phase_next = PH_KEY_START;
                    else if (c == CH_CLOSE)
                        phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end

        res_next.pair_done        = pair;
        res_next.pair_is_integer  = int_mode_next;
        res_next.int_result       = acc_next;
        res_next.key_char_valid   = kv;
        res_next.value_char_valid = vv;
        res_next.char_out         = (kv || vv) ? c : 8'h00;
        res_next.key_count        = COUNT_W'(key_len_next);
        res_next.value_count      = COUNT_W'(val_len_next);
        res_next.truncated        = trunc;
        res_next.finished         = (phase_next == PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_CRLF;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= 8'h00;
            end
            fill_reg      <= '0;
            int_mode_reg  <= 1'b0;
            acc_reg       <= '0;
            key_len_reg   <= '0;
            val_len_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            int_mode_reg  <= int_mode_next;
            acc_reg       <= acc_next;
            key_len_reg   <= key_len_next;
            val_len_reg   <= val_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {res_reg.value_char_valid, res_reg.key_char_valid};
    assign m_tdata  = {1'b0,
                       res_reg.finished,
                       res_reg.truncated,
                       res_reg.value_count,
                       res_reg.key_count,
                       res_reg.char_out,
                       res_reg.int_result,
                       res_reg.pair_is_integer,
                       res_reg.pair_done};

`ifndef NO_ASSERTIONS
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_LEN - 1))
        else $error("window fill beyond window");

    a_trunc_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.truncated |->
            (key_len_reg == LEN_W'(FIELD_LEN) || val_len_reg == LEN_W'(FIELD_LEN)))
        else $error("drop flagged with room left in buffer");

    a_strobe_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.key_char_valid || res_reg.value_char_valid) |->
            !res_reg.finished && !(res_reg.key_char_valid && res_reg.value_char_valid))
        else $error("character strobe inconsistent with phase");
`endif

endmodule
